@@ hdl/v2dc_pkg.sv @@
// Shared constants, types and helpers of the valid 2D convolution unit.
package v2dc_pkg;

	localparam int MAX_WIDTH  = 1024;
	localparam int MAX_HEIGHT = 1024;
	localparam int MAX_KERNEL = 8;

	localparam int COL_W   = $clog2(MAX_WIDTH);
	localparam int ROW_W   = $clog2(MAX_HEIGHT);
	localparam int SLOT_W  = (MAX_KERNEL > 1) ? $clog2(MAX_KERNEL) : 1;
	localparam int DATA_W  = 16;
	localparam int PROD_W  = 2 * DATA_W;
	localparam int GRP_W   = PROD_W + SLOT_W;
	localparam int SUM_W   = 38;
	localparam int SIZE_W  = 11;
	localparam int KSIZE_W = 4;
	localparam int POS_W   = 10;

	localparam logic [1:0] REG_IMAGE_HEIGHT  = 2'd0;
	localparam logic [1:0] REG_IMAGE_WIDTH   = 2'd1;
	localparam logic [1:0] REG_KERNEL_HEIGHT = 2'd2;
	localparam logic [1:0] REG_KERNEL_WIDTH  = 2'd3;

	localparam logic CMD_LOAD   = 1'b0;
	localparam logic CMD_SAMPLE = 1'b1;

	// one line store entry: the samples of one image column, one per row slot
	typedef logic [MAX_KERNEL-1:0][DATA_W-1:0] column_t;

	// request moving from the line store stage into the MAC datapath
	typedef struct packed {
		logic               valid;
		logic               cmd;
		logic [2:0]         krow;
		logic [2:0]         kcol;
		logic [DATA_W-1:0]  value;
		logic [SLOT_W-1:0]  slot;
		logic               emit;
		logic               last;
		logic [POS_W-1:0]   out_row;
		logic [POS_W-1:0]   out_col;
	} step_t;

	typedef struct packed {
		logic               valid;
		logic               last;
		logic [POS_W-1:0]   out_row;
		logic [POS_W-1:0]   out_col;
	} meta_t;

	function automatic logic [SIZE_W-1:0] clamp_size(input logic [SIZE_W-1:0] v,
			input logic [SIZE_W-1:0] hi);
		logic [SIZE_W-1:0] r;
		if (v == '0)
			r = SIZE_W'(1);
		else if (v > hi)
			r = hi;
		else
			r = v;
		return r;
	endfunction

endpackage

@@ hdl/v2dc_line_mem.sv @@
// Line store memory: one entry per image column, holding all row slots.
module v2dc_line_mem (
	input  logic                        clk,
	input  logic                        rd_en,
	input  logic [v2dc_pkg::COL_W-1:0]  rd_addr,
	output v2dc_pkg::column_t           rd_data,
	input  logic                        wr_en,
	input  logic [v2dc_pkg::COL_W-1:0]  wr_addr,
	input  v2dc_pkg::column_t           wr_data
);

	v2dc_pkg::column_t mem [v2dc_pkg::MAX_WIDTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

@@ hdl/v2dc_mac.sv @@
// Window registers, kernel store, product array and adder tree.
module v2dc_mac (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            adv,
	input  v2dc_pkg::step_t                 step,
	input  v2dc_pkg::column_t               column,
	input  logic [v2dc_pkg::KSIZE_W-1:0]    kh,
	input  logic [v2dc_pkg::KSIZE_W-1:0]    kw,
	output v2dc_pkg::meta_t                 meta_s4,
	output logic signed [v2dc_pkg::SUM_W-1:0] sum_s4
);

	localparam int MK = v2dc_pkg::MAX_KERNEL;

	// win[a] is the column a samples back in the current row
	v2dc_pkg::column_t win_q [MK];
	logic [v2dc_pkg::DATA_W-1:0] kern_q [MK][MK];

	v2dc_pkg::meta_t meta_s2, meta_s3;
	logic [v2dc_pkg::SLOT_W-1:0] slot_s2;
	logic signed [v2dc_pkg::PROD_W-1:0] prod_s3 [MK][MK];
	logic signed [v2dc_pkg::GRP_W-1:0] grp_s4 [MK];

	always_ff @(posedge clk) begin
		if (adv && step.valid) begin
			if (step.cmd == v2dc_pkg::CMD_SAMPLE) begin
				win_q[0] <= column;
				for (int a = 1; a < MK; a++) begin
					win_q[a] <= win_q[a-1];
				end
			end else begin
				for (int b = 0; b < MK; b++) begin
					for (int a = 0; a < MK; a++) begin
						if (step.krow == 3'(b) && step.kcol == 3'(a)) begin
							kern_q[b][a] <= step.value;
						end
					end
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			meta_s2 <= '0;
			meta_s3 <= '0;
			meta_s4 <= '0;
		end else if (adv) begin
			meta_s2.valid   <= step.valid && step.cmd == v2dc_pkg::CMD_SAMPLE && step.emit;
			meta_s2.last    <= step.last;
			meta_s2.out_row <= step.out_row;
			meta_s2.out_col <= step.out_col;
			meta_s3         <= meta_s2;
			meta_s4         <= meta_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			slot_s2 <= step.slot;
		end
	end

	// product for kernel row b, column a takes the sample b rows up, a columns back
	always_ff @(posedge clk) begin
		if (adv) begin
			for (int b = 0; b < MK; b++) begin
				for (int a = 0; a < MK; a++) begin
					if (4'(a) < kw && 4'(b) < kh) begin
						prod_s3[b][a] <= $signed(win_q[a][slot_s2 - v2dc_pkg::SLOT_W'(b)])
							* $signed(kern_q[b][a]);
					end else begin
						prod_s3[b][a] <= '0;
					end
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int b = 0; b < MK; b++) begin
				logic signed [v2dc_pkg::GRP_W-1:0] acc;
				acc = '0;
				for (int a = 0; a < MK; a++) begin
					acc = acc + v2dc_pkg::GRP_W'(prod_s3[b][a]);
				end
				grp_s4[b] <= acc;
			end
		end
	end

	always_comb begin
		sum_s4 = '0;
		for (int b = 0; b < MK; b++) begin
			sum_s4 = sum_s4 + v2dc_pkg::SUM_W'(grp_s4[b]);
		end
	end

endmodule

@@ hdl/valid_2d_convolution_unit.sv @@
// Top level of the valid-size 2D convolution unit with flipped kernel.
//
// Load the kernel first with command 0 requests (tuser low), one coefficient
// each, then stream image samples in raster order with command 1 (tuser high).
// The unit takes one request per cycle while the output side keeps up; a
// stalled output holds the whole pipeline. Each sample yields one result once
// its kernel window is complete. It passes the line store read, the column
// merge into the window registers, the 64 parallel multipliers and the adder
// tree, whose row sums are registered and whose total feeds the output
// register. The line store keeps one column per entry, all eight row slots
// side by side, and is read, updated and written back per sample; a sample in
// the same column as the one just before it takes the forwarded column.
// Coefficient loads take effect in stream order. A register write restarts the
// image at row zero; write registers only while the unit is idle. Out-of-range
// sizes are saturated to their legal range.
module valid_2d_convolution_unit (
	input  logic        clk,
	input  logic        arst_n,
	// configuration write channel
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [10:0] cfg_data,
	// input stream
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [23:0] s_tdata,   // coeff_row[2:0], coeff_col[5:3], value[21:6], zero pad
	input  logic        s_tuser,   // command
	// result stream
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [63:0] m_tdata,   // out_value[37:0], out_row[47:38], out_col[57:48], zero pad
	output logic        m_tlast    // last_of_image
);

	localparam int CW = v2dc_pkg::COL_W;
	localparam int RW = v2dc_pkg::ROW_W;
	localparam int SW = v2dc_pkg::SIZE_W;
	localparam int KSW = v2dc_pkg::KSIZE_W;

	logic [SW-1:0]  img_h_q, img_w_q;
	logic [KSW-1:0] ker_h_q, ker_w_q;
	logic [SW-1:0]  h, w;
	logic [KSW-1:0] kh, kw;

	logic [RW-1:0] row_q, r;
	logic [CW-1:0] col_q, c;

	logic adv, acc;
	logic emit, last;

	v2dc_pkg::step_t step_s1;
	logic [CW-1:0] col_s1;
	logic fwd_s1;
	v2dc_pkg::column_t rd_data, merged, last_wr_q;

	v2dc_pkg::meta_t meta_s4;
	logic signed [v2dc_pkg::SUM_W-1:0] sum_s4;

	logic out_valid_q, out_last_q;
	logic [v2dc_pkg::SUM_W-1:0] out_sum_q;
	logic [v2dc_pkg::POS_W-1:0] out_row_q, out_col_q;

	assign cfg_ready = 1'b1;

	// hold the whole pipeline while a result waits
	assign adv      = !out_valid_q || m_tready;
	assign s_tready = adv;
	assign acc      = s_tvalid && adv;

	assign h  = v2dc_pkg::clamp_size(img_h_q, SW'(v2dc_pkg::MAX_HEIGHT));
	assign w  = v2dc_pkg::clamp_size(img_w_q, SW'(v2dc_pkg::MAX_WIDTH));
	assign kh = KSW'(v2dc_pkg::clamp_size(SW'(ker_h_q), SW'(v2dc_pkg::MAX_KERNEL)));
	assign kw = KSW'(v2dc_pkg::clamp_size(SW'(ker_w_q), SW'(v2dc_pkg::MAX_KERNEL)));

	// wrap counters left out of range by a smaller image
	assign r = (SW'(row_q) >= h) ? '0 : row_q;
	assign c = (SW'(col_q) >= w) ? '0 : col_q;

	assign emit = (SW'(r) + SW'(1) >= SW'(kh)) && (SW'(c) + SW'(1) >= SW'(kw));
	assign last = (SW'(r) + SW'(1) == h) && (SW'(c) + SW'(1) == w);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			img_h_q <= SW'(1024);
			img_w_q <= SW'(1024);
			ker_h_q <= KSW'(3);
			ker_w_q <= KSW'(3);
			row_q   <= '0;
			col_q   <= '0;
		end else if (cfg_valid) begin
			case (cfg_index)
				v2dc_pkg::REG_IMAGE_HEIGHT:  img_h_q <= cfg_data;
				v2dc_pkg::REG_IMAGE_WIDTH:   img_w_q <= cfg_data;
				v2dc_pkg::REG_KERNEL_HEIGHT: ker_h_q <= cfg_data[KSW-1:0];
				v2dc_pkg::REG_KERNEL_WIDTH:  ker_w_q <= cfg_data[KSW-1:0];
				default: ;
			endcase
			// restart the image
			row_q <= '0;
			col_q <= '0;
		end else if (acc && s_tuser == v2dc_pkg::CMD_SAMPLE) begin
			if (SW'(c) + SW'(1) >= w) begin
				col_q <= '0;
				row_q <= (SW'(r) + SW'(1) >= h) ? '0 : r + RW'(1);
			end else begin
				col_q <= c + CW'(1);
			end
		end
	end

	// stage 1: line store read in flight
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_s1 <= '0;
		end else if (adv) begin
			step_s1.valid   <= acc;
			step_s1.cmd     <= s_tuser;
			step_s1.krow    <= s_tdata[2:0];
			step_s1.kcol    <= s_tdata[5:3];
			step_s1.value   <= s_tdata[21:6];
			step_s1.slot    <= r[v2dc_pkg::SLOT_W-1:0];
			step_s1.emit    <= emit;
			step_s1.last    <= last;
			step_s1.out_row <= v2dc_pkg::POS_W'(SW'(r) + SW'(1) - SW'(kh));
			step_s1.out_col <= v2dc_pkg::POS_W'(SW'(c) + SW'(1) - SW'(kw));
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			col_s1          <= c;
			// forward the column written this edge when the next sample reads it
			fwd_s1          <= step_s1.valid && step_s1.cmd == v2dc_pkg::CMD_SAMPLE
				&& col_s1 == c;
			last_wr_q       <= merged;
		end
	end

	always_comb begin
		merged = fwd_s1 ? last_wr_q : rd_data;
		merged[step_s1.slot] = step_s1.value;
	end

	v2dc_line_mem u_line_mem (
		.clk     (clk),
		.rd_en   (acc),
		.rd_addr (c),
		.rd_data (rd_data),
		.wr_en   (adv && step_s1.valid && step_s1.cmd == v2dc_pkg::CMD_SAMPLE),
		.wr_addr (col_s1),
		.wr_data (merged)
	);

	v2dc_mac u_mac (
		.clk     (clk),
		.arst_n  (arst_n),
		.adv     (adv),
		.step    (step_s1),
		.column  (merged),
		.kh      (kh),
		.kw      (kw),
		.meta_s4 (meta_s4),
		.sum_s4  (sum_s4)
	);

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= meta_s4.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			out_sum_q  <= sum_s4;
			out_row_q  <= meta_s4.out_row;
			out_col_q  <= meta_s4.out_col;
			out_last_q <= meta_s4.last;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {6'd0, out_col_q, out_row_q, out_sum_q};
	assign m_tlast  = out_last_q;

endmodule
